[rtl/bfit_pkg.sv]
// ----------------------------------------------------------------------------
// bfit_pkg
// Types and constants shared by the instruction translator modules.
// ----------------------------------------------------------------------------
package bfit_pkg;

	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;

	localparam logic [15:0] RUN_MAX = 16'hFFFF;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_INC_PTR  = 4'd1,
		OP_DEC_PTR  = 4'd2,
		OP_INC_DATA = 4'd3,
		OP_DEC_DATA = 4'd4,
		OP_READ     = 4'd5,
		OP_WRITE    = 4'd6,
		OP_SET_ZERO = 4'd7,
		OP_MOVE_PTR = 4'd8,
		OP_MOVE_DAT = 4'd9,
		OP_JZ       = 4'd10,
		OP_JNZ      = 4'd11
	} op_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_UNMATCHED = 3'd1,
		ERR_BAD_CHAR  = 3'd2,
		ERR_STACK     = 3'd3,
		ERR_FULL      = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_FLUSH,
		ST_OPEN,
		ST_CLOSE,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_RD4,
		ST_EVAL,
		ST_PATCH,
		ST_BACKJ,
		ST_ERR,
		ST_TAIL
	} state_t;

	typedef struct packed {
		logic        write_valid;
		logic [11:0] write_index;
		logic [3:0]  op_kind;
		logic [16:0] op_argument;
		logic [12:0] op_count;
		logic [2:0]  error_code;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_program;
	} item_t;

	function automatic logic [3:0] run_kind(input logic [7:0] c);
		unique case (c)
			CH_GT:    return OP_INC_PTR;
			CH_LT:    return OP_DEC_PTR;
			CH_PLUS:  return OP_INC_DATA;
			CH_MINUS: return OP_DEC_DATA;
			CH_COMMA: return OP_READ;
			CH_DOT:   return OP_WRITE;
			default:  return OP_NONE;
		endcase
	endfunction

endpackage

[rtl/bfit_stream_if.sv]
// ----------------------------------------------------------------------------
// bfit_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bfit_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/bfit_ram.sv]
// ----------------------------------------------------------------------------
// bfit_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/bf_instruction_translator_unit.sv]
// ----------------------------------------------------------------------------
// bf_instruction_translator_unit
// One character per transaction. A run character passes the decide state, and
// the tail state too when it closes a pending run or ends the program; a sticky
// error passes decide alone; an opening bracket or a bad character goes on
// through flush to the open or error state. A closing bracket reads the
// open-bracket stack and then four stored ops from the op memory, one per
// cycle, and then evaluates the loop. Results leave through an output
// register, one per cycle at most, and the sequencer stalls while that
// register is full and the receiver is not ready. The op memory and the
// open-bracket stack are synchronous RAMs and need no clearing after reset.
// ----------------------------------------------------------------------------
module bf_instruction_translator_unit #(
	parameter int OP_DEPTH    = 4096,
	parameter int STACK_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	bfit_stream_if.sink   in_ch,
	bfit_stream_if.source out_ch
);
	localparam int OAW = $clog2(OP_DEPTH);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int OTW = OAW + 1;
	localparam int SLW = SAW + 1;
	localparam logic [OTW-1:0] OP_FULL = OTW'(OP_DEPTH);
	localparam logic [SLW-1:0] ST_FULL = SLW'(STACK_DEPTH);

	bfit_pkg::state_t state_q, state_d;
	logic [7:0]     ch_q;
	logic           end_q;
	logic [OTW-1:0] total_q;
	logic [SLW-1:0] level_q;
	logic [7:0]     run_char_q;
	logic [15:0]    run_len_q;
	logic [2:0]     err_q;
	logic [OTW-1:0] start_q;
	logic [3:0]     k1_q, k2_q, k3_q;
	logic [16:0]    a1_q, a2_q, a3_q;

	// output register
	logic            ov_q;
	bfit_pkg::result_t od_q;
	logic            emit;
	bfit_pkg::result_t res;

	// op memory
	logic           op_we;
	logic [OAW-1:0] op_wa, op_ra;
	logic [20:0]    op_wd, op_rd;
	// stack memory
	logic           st_we;
	logic [SAW-1:0] st_wa, st_ra;
	logic [OAW-1:0] st_wd, st_rd;

	bfit_ram #(.WIDTH(21), .DEPTH(OP_DEPTH)) u_op_ram (
		.clk(clk), .we(op_we), .waddr(op_wa), .wdata(op_wd),
		.raddr(op_ra), .rdata(op_rd));
	bfit_ram #(.WIDTH(OAW), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(st_ra), .rdata(st_rd));

	logic out_free;
	assign out_free = !ov_q || out_ch.ready;
	assign in_ch.ready = (state_q == bfit_pkg::ST_IDLE);
	assign out_ch.valid = ov_q;
	assign out_ch.data = od_q;

	logic [3:0]  rk_in, rk_run, rd_k;
	logic [16:0] rd_a;
	logic        is_run, need_flush, run_pend;
	logic [OTW-1:0] len;
	assign rk_in = bfit_pkg::run_kind(ch_q);
	assign rk_run = bfit_pkg::run_kind(run_char_q);
	assign is_run = (rk_in != bfit_pkg::OP_NONE);
	assign run_pend = (run_char_q != 8'd0);
	assign need_flush = run_pend && (ch_q != run_char_q || run_len_q >= bfit_pkg::RUN_MAX);
	assign rd_k = op_rd[20:17];
	assign rd_a = op_rd[16:0];
	assign len = total_q - start_q;

	// idiom evaluation uses k1..k3 plus current read (entry 4)
	logic        idm;
	logic [3:0]  idk;
	logic [16:0] ida;
	always_comb begin
		idm = 1'b0;
		idk = bfit_pkg::OP_NONE;
		ida = '0;
		if (len == OTW'(2)) begin
			if (k1_q == bfit_pkg::OP_INC_DATA || k1_q == bfit_pkg::OP_DEC_DATA) begin
				idm = 1'b1; idk = bfit_pkg::OP_SET_ZERO;
			end else if (k1_q == bfit_pkg::OP_INC_PTR) begin
				idm = 1'b1; idk = bfit_pkg::OP_MOVE_PTR; ida = a1_q;
			end else if (k1_q == bfit_pkg::OP_DEC_PTR) begin
				idm = 1'b1; idk = bfit_pkg::OP_MOVE_PTR; ida = -a1_q;
			end
		end else if (len == OTW'(5)) begin
			if (k1_q == bfit_pkg::OP_DEC_DATA && k3_q == bfit_pkg::OP_INC_DATA &&
					a1_q == 17'd1 && a3_q == 17'd1 && a2_q == rd_a) begin
				if (k2_q == bfit_pkg::OP_INC_PTR && rd_k == bfit_pkg::OP_DEC_PTR) begin
					idm = 1'b1; idk = bfit_pkg::OP_MOVE_DAT; ida = a2_q;
				end else if (k2_q == bfit_pkg::OP_DEC_PTR && rd_k == bfit_pkg::OP_INC_PTR) begin
					idm = 1'b1; idk = bfit_pkg::OP_MOVE_DAT; ida = -a2_q;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfit_pkg::ST_IDLE: if (in_ch.valid) state_d = bfit_pkg::ST_DECIDE;
			bfit_pkg::ST_DECIDE: begin
				if (!out_free) state_d = state_q;
				else if (err_q != bfit_pkg::ERR_NONE) state_d = bfit_pkg::ST_IDLE;
				else if (is_run) begin
					if (need_flush && total_q >= OP_FULL) state_d = bfit_pkg::ST_IDLE;
					else if (need_flush || end_q) state_d = bfit_pkg::ST_TAIL;
					else state_d = bfit_pkg::ST_IDLE;
				end else if (run_pend) begin
					state_d = (total_q >= OP_FULL) ? bfit_pkg::ST_IDLE : bfit_pkg::ST_FLUSH;
				end else state_d = bfit_pkg::ST_FLUSH;
			end
			bfit_pkg::ST_FLUSH: begin
				if (ch_q == bfit_pkg::CH_OPEN) state_d = bfit_pkg::ST_OPEN;
				else if (ch_q == bfit_pkg::CH_CLOSE) state_d = bfit_pkg::ST_CLOSE;
				else state_d = bfit_pkg::ST_ERR;
			end
			bfit_pkg::ST_OPEN: if (out_free) state_d = bfit_pkg::ST_IDLE;
			bfit_pkg::ST_ERR: if (out_free) state_d = bfit_pkg::ST_IDLE;
			bfit_pkg::ST_CLOSE: if (out_free) state_d = (level_q == '0) ?
				bfit_pkg::ST_IDLE : bfit_pkg::ST_RD1;
			bfit_pkg::ST_RD1: state_d = bfit_pkg::ST_RD2;
			bfit_pkg::ST_RD2: state_d = bfit_pkg::ST_RD3;
			bfit_pkg::ST_RD3: state_d = bfit_pkg::ST_RD4;
			bfit_pkg::ST_RD4: state_d = bfit_pkg::ST_EVAL;
			bfit_pkg::ST_EVAL: if (out_free) state_d = bfit_pkg::ST_PATCH;
			bfit_pkg::ST_PATCH: if (out_free) state_d = bfit_pkg::ST_BACKJ;
			bfit_pkg::ST_BACKJ: if (out_free) state_d = bfit_pkg::ST_IDLE;
			bfit_pkg::ST_TAIL: if (out_free) state_d = bfit_pkg::ST_IDLE;
			default: state_d = bfit_pkg::ST_IDLE;
		endcase
	end

	function automatic bfit_pkg::result_t mk(input logic v, input logic [OAW-1:0] i,
			input logic [3:0] k, input logic [16:0] a, input logic [OTW-1:0] cnt,
			input logic [2:0] e, input logic l);
		bfit_pkg::result_t r;
		r.write_valid = v;
		r.write_index = 12'(i);
		r.op_kind = k;
		r.op_argument = a;
		r.op_count = 13'(cnt);
		r.error_code = e;
		r.last_of_run = l;
		return r;
	endfunction

	// outputs and memory controls
	logic [OTW-1:0] tot_n;
	always_comb begin
		emit = 1'b0;
		res = '0;
		op_we = 1'b0;
		op_wa = total_q[OAW-1:0];
		op_wd = '0;
		op_ra = '0;
		st_we = 1'b0;
		st_wa = level_q[SAW-1:0];
		st_wd = total_q[OAW-1:0];
		st_ra = SAW'(level_q - SLW'(1));
		tot_n = total_q;
		unique case (state_q)
			bfit_pkg::ST_DECIDE: if (out_free) begin
				if (err_q != bfit_pkg::ERR_NONE) begin
					emit = 1'b1;
					res = mk(1'b0, '0, '0, '0, total_q, err_q, 1'b1);
				end else if (need_flush || (!is_run && run_pend)) begin
					if (total_q >= OP_FULL) begin
						emit = 1'b1;
						res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_FULL, 1'b1);
					end else begin
						emit = 1'b1;
						op_we = 1'b1;
						op_wd = {rk_run, 1'b0, run_len_q};
						tot_n = total_q + OTW'(1);
						res = mk(1'b1, total_q[OAW-1:0], rk_run, {1'b0, run_len_q}, tot_n,
							bfit_pkg::ERR_NONE, is_run && !end_q);
					end
				end
			end
			bfit_pkg::ST_TAIL: if (out_free && end_q) begin
				emit = 1'b1;
				if (total_q >= OP_FULL)
					res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_FULL, 1'b1);
				else begin
					op_we = 1'b1;
					op_wd = {rk_run, 1'b0, run_len_q};
					tot_n = total_q + OTW'(1);
					res = mk(1'b1, total_q[OAW-1:0], rk_run, {1'b0, run_len_q}, tot_n,
						bfit_pkg::ERR_NONE, 1'b1);
				end
			end
			bfit_pkg::ST_ERR: if (out_free) begin
				emit = 1'b1;
				res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_BAD_CHAR, 1'b1);
			end
			bfit_pkg::ST_OPEN: if (out_free) begin
				emit = 1'b1;
				if (level_q >= ST_FULL)
					res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_STACK, 1'b1);
				else if (total_q >= OP_FULL)
					res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_FULL, 1'b1);
				else begin
					op_we = 1'b1;
					op_wd = {4'(bfit_pkg::OP_JZ), 17'd0};
					st_we = 1'b1;
					tot_n = total_q + OTW'(1);
					res = mk(1'b1, total_q[OAW-1:0], bfit_pkg::OP_JZ, '0, tot_n,
						bfit_pkg::ERR_NONE, 1'b1);
				end
			end
			bfit_pkg::ST_CLOSE: if (out_free && level_q == '0) begin
				emit = 1'b1;
				res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_UNMATCHED, 1'b1);
			end
			bfit_pkg::ST_RD1: op_ra = OAW'(st_rd + OAW'(1));
			bfit_pkg::ST_RD2: op_ra = OAW'(start_q + OTW'(2));
			bfit_pkg::ST_RD3: op_ra = OAW'(start_q + OTW'(3));
			bfit_pkg::ST_RD4: op_ra = OAW'(start_q + OTW'(4));
			bfit_pkg::ST_EVAL: begin
				op_ra = OAW'(start_q + OTW'(4));
				if (out_free) begin
					if (start_q >= total_q) begin
						emit = 1'b0;
					end
					if (start_q < total_q && idm) begin
						emit = 1'b1;
						op_we = 1'b1;
						op_wa = start_q[OAW-1:0];
						op_wd = {idk, ida};
						tot_n = start_q + OTW'(1);
						res = mk(1'b1, start_q[OAW-1:0], idk, ida, tot_n,
							bfit_pkg::ERR_NONE, 1'b1);
					end else if (total_q >= OP_FULL) begin
						emit = 1'b1;
						res = mk(1'b0, '0, '0, '0, total_q, bfit_pkg::ERR_FULL, 1'b1);
					end
				end
			end
			bfit_pkg::ST_PATCH: if (out_free) begin
				emit = 1'b1;
				op_we = 1'b1;
				op_wa = start_q[OAW-1:0];
				op_wd = {4'(bfit_pkg::OP_JZ), 17'(total_q)};
				res = mk(1'b1, start_q[OAW-1:0], bfit_pkg::OP_JZ, 17'(total_q), total_q,
					bfit_pkg::ERR_NONE, 1'b0);
			end
			bfit_pkg::ST_BACKJ: if (out_free) begin
				emit = 1'b1;
				op_we = 1'b1;
				op_wd = {4'(bfit_pkg::OP_JNZ), 17'(start_q)};
				tot_n = total_q + OTW'(1);
				res = mk(1'b1, total_q[OAW-1:0], bfit_pkg::OP_JNZ, 17'(start_q), tot_n,
					bfit_pkg::ERR_NONE, 1'b1);
			end
			default: ;
		endcase
	end

	// EVAL exit: idiom or error ends the item
	logic eval_done;
	assign eval_done = (state_q == bfit_pkg::ST_EVAL) && out_free &&
		((start_q < total_q && idm) || total_q >= OP_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfit_pkg::ST_IDLE;
			total_q <= '0;
			level_q <= '0;
			run_char_q <= '0;
			run_len_q <= '0;
			err_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= eval_done ? bfit_pkg::ST_IDLE : state_d;
			total_q <= tot_n;
			if (emit) begin
				ov_q <= 1'b1;
				if (!res.write_valid)
					err_q <= res.error_code;
			end else if (out_ch.ready)
				ov_q <= 1'b0;
			unique case (state_q)
				bfit_pkg::ST_DECIDE: if (out_free && err_q == bfit_pkg::ERR_NONE) begin
					if (is_run) begin
						if (!(need_flush && total_q >= OP_FULL)) begin
							if (need_flush || !run_pend) begin
								run_char_q <= ch_q;
								run_len_q <= 16'd1;
							end else
								run_len_q <= run_len_q + 16'd1;
						end
					end else if (run_pend && total_q < OP_FULL) begin
						run_char_q <= '0;
						run_len_q <= '0;
					end
				end
				bfit_pkg::ST_TAIL: begin
					if (out_free && end_q && total_q < OP_FULL) begin
						run_char_q <= '0;
						run_len_q <= '0;
					end
				end
				bfit_pkg::ST_OPEN: if (st_we) level_q <= level_q + SLW'(1);
				bfit_pkg::ST_CLOSE: if (out_free && level_q != '0) level_q <= level_q - SLW'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			ch_q <= in_ch.data.char_code;
			end_q <= in_ch.data.end_of_program;
		end
		if (emit)
			od_q <= res;
		unique case (state_q)
			bfit_pkg::ST_RD1: start_q <= {1'b0, st_rd};
			bfit_pkg::ST_RD2: begin k1_q <= rd_k; a1_q <= rd_a; end
			bfit_pkg::ST_RD3: begin k2_q <= rd_k; a2_q <= rd_a; end
			bfit_pkg::ST_RD4: begin k3_q <= rd_k; a3_q <= rd_a; end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= ST_FULL) else $error("stack level beyond depth");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= OP_FULL) else $error("op total beyond depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ch.ready |=> $stable(od_q)) else $error("result overwritten");
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != bfit_pkg::ERR_NONE |=> err_q == $past(err_q)) else $error("error not sticky");
`endif
endmodule

[tb/sv/bf_instruction_translator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_instruction_translator_unit_tb
// Feeds program characters to the translator and checks every op store write
// and error against a predictor of the op list, the open-bracket stack and
// the pending run. Covers loop idioms, run merging, nesting, and one
// sticky error per run, chosen at random.
// ----------------------------------------------------------------------------
module bf_instruction_translator_unit_tb;
	import bfit_pkg::*;

	localparam int OPS    = 4096;
	localparam int STACKS = 256;

	class op_list_scoreboard;
		logic [3:0]  kinds [OPS];
		int          args [OPS];
		int unsigned total;
		int unsigned opens [STACKS];
		int unsigned level;
		logic [7:0]  run_c;
		int unsigned run_len;
		logic [2:0]  err;
		result_t     pending [$];
		result_t     step_res [$];
		int          mismatches;

		function new();
			total = 0;
			level = 0;
			run_c = 8'd0;
			run_len = 0;
			err = ERR_NONE;
			mismatches = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		function void emit(logic v, int unsigned idx, logic [3:0] k, int a, logic [2:0] e);
			result_t r;
			r.write_valid = v;
			r.write_index = idx[11:0];
			r.op_kind     = k;
			r.op_argument = a[16:0];
			r.op_count    = total[12:0];
			r.error_code  = e;
			r.last_of_run = 1'b0;
			step_res.insert(step_res.size(), r);
		endfunction

		function void raise(logic [2:0] e);
			err = e;
			emit(1'b0, 0, OP_NONE, 0, e);
		endfunction

		function void put(int unsigned idx, logic [3:0] k, int a);
			kinds[idx] = k;
			args[idx] = a;
			emit(1'b1, idx, k, a, ERR_NONE);
		endfunction

		function bit append(logic [3:0] k, int a);
			if (total >= OPS) begin
				raise(ERR_FULL);
				return 1'b0;
			end
			total++;
			put(total - 1, k, a);
			return 1'b1;
		endfunction

		function bit flush_run();
			logic [3:0] k;
			int a;
			if (run_c == 8'd0) return 1'b1;
			k = run_kind(run_c);
			a = run_len;
			run_c = 8'd0;
			run_len = 0;
			return append(k, a);
		endfunction

		function bit loop_idiom(int unsigned s, output logic [3:0] k, output int a);
			k = OP_NONE;
			a = 0;
			if (s >= total) return 1'b0;
			if (total - s == 2) begin
				case (kinds[s+1])
					OP_INC_DATA, OP_DEC_DATA: begin k = OP_SET_ZERO; a = 0; return 1'b1; end
					OP_INC_PTR: begin k = OP_MOVE_PTR; a = args[s+1]; return 1'b1; end
					OP_DEC_PTR: begin k = OP_MOVE_PTR; a = -args[s+1]; return 1'b1; end
					default: ;
				endcase
			end else if (total - s == 5) begin
				if (kinds[s+1] == OP_DEC_DATA && kinds[s+3] == OP_INC_DATA &&
						args[s+1] == 1 && args[s+3] == 1 && args[s+2] == args[s+4]) begin
					if (kinds[s+2] == OP_INC_PTR && kinds[s+4] == OP_DEC_PTR) begin
						k = OP_MOVE_DAT; a = args[s+2]; return 1'b1;
					end
					if (kinds[s+2] == OP_DEC_PTR && kinds[s+4] == OP_INC_PTR) begin
						k = OP_MOVE_DAT; a = -args[s+2]; return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function void note(item_t it);
			logic [7:0] c;
			int unsigned s;
			logic [3:0] k;
			int a;
			bit ok;
			c = it.char_code;
			step_res.delete();
			if (err != ERR_NONE) begin
				emit(1'b0, 0, OP_NONE, 0, err);
			end else if (c == CH_OPEN) begin
				if (flush_run()) begin
					if (level >= STACKS) raise(ERR_STACK);
					else if (append(OP_JZ, 0)) begin
						opens[level] = total - 1;
						level++;
					end
				end
			end else if (c == CH_CLOSE) begin
				if (flush_run()) begin
					if (level == 0) begin
						raise(ERR_UNMATCHED);
					end else begin
						level--;
						s = opens[level];
						if (loop_idiom(s, k, a)) begin
							total = s + 1;
							put(s, k, a);
						end else if (total >= OPS) begin
							raise(ERR_FULL);
						end else begin
							put(s, OP_JZ, total);
							void'(append(OP_JNZ, s));
						end
					end
				end
			end else if (run_kind(c) != OP_NONE) begin
				ok = 1'b1;
				if (run_c != 8'd0 && (c != run_c || run_len >= RUN_MAX)) ok = flush_run();
				if (ok) begin
					if (run_c == 8'd0) begin
						run_c = c;
						run_len = 1;
					end else begin
						run_len++;
					end
					if (it.end_of_program) void'(flush_run());
				end
			end else begin
				if (flush_run()) raise(ERR_BAD_CHAR);
			end
			if (step_res.size() > 0) step_res[$].last_of_run = 1'b1;
			foreach (step_res[i]) pending.insert(pending.size(), step_res[i]);
		endfunction

		task check(result_t g);
			result_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %h", g));
				return;
			end
			e = pending.pop_front();
			if (g.write_valid !== e.write_valid)
				report($sformatf("write_valid got %0d exp %0d", g.write_valid, e.write_valid));
			if (g.write_index !== e.write_index)
				report($sformatf("write_index got %0d exp %0d", g.write_index, e.write_index));
			if (g.op_kind !== e.op_kind)
				report($sformatf("op_kind got %0d exp %0d", g.op_kind, e.op_kind));
			if (g.op_argument !== e.op_argument)
				report($sformatf("op_argument got %h exp %h", g.op_argument, e.op_argument));
			if (g.op_count !== e.op_count)
				report($sformatf("op_count got %0d exp %0d", g.op_count, e.op_count));
			if (g.error_code !== e.error_code)
				report($sformatf("error_code got %0d exp %0d", g.error_code, e.error_code));
			if (g.last_of_run !== e.last_of_run)
				report($sformatf("last_of_run got %0d exp %0d", g.last_of_run, e.last_of_run));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	int   open_depth;
	op_list_scoreboard sb;

	bfit_stream_if #(.T(item_t))   in_ch();
	bfit_stream_if #(.T(result_t)) out_ch();

	bf_instruction_translator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready = ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) sb.check(out_ch.data);
		if (in_ch.valid && in_ch.ready) sb.note(in_ch.data);
	end

	task send(logic [7:0] c, logic e);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data = '{char_code: c, end_of_program: e};
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (c == CH_OPEN) open_depth++;
		else if (c == CH_CLOSE && open_depth > 0) open_depth--;
	endtask

	task send_text(string s);
		for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
	endtask

	task random_program(int n);
		logic [7:0] runs [6];
		logic [7:0] c;
		int sent;
		int len;
		runs = '{CH_GT, CH_LT, CH_PLUS, CH_MINUS, CH_COMMA, CH_DOT};
		sent = 0;
		while (sent < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					c = runs[$urandom_range(5)];
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++) send(c, $urandom_range(9) == 0);
					sent += len;
				end
				4, 5: begin send(CH_OPEN, $urandom_range(1)); sent++; end
				6: begin
					if (open_depth > 0) begin send(CH_CLOSE, $urandom_range(1)); sent++; end
				end
				7: begin
					case ($urandom_range(5))
						0: send_text("[-]");
						1: send_text("[+]");
						2: send_text("[>>>]");
						3: send_text("[<<]");
						4: send_text("[-<<+>>]");
						default: send_text("[->+<]");
					endcase
					sent += 5;
				end
				default: begin
					case ($urandom_range(3))
						0: send_text("[-<+>>]");
						1: send_text("[--<+>]");
						2: send_text("[+>]");
						default: send_text("[-<+>.]");
					endcase
					sent += 6;
				end
			endcase
		end
		while (open_depth > 0) send(CH_CLOSE, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		send_idle = 34;
		recv_idle = 72;
		open_depth = 0;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(CH_GT, 1'b0); send(CH_LT, 1'b1); send(CH_PLUS, 1'b0); send(CH_MINUS, 1'b0);
		send(CH_COMMA, 1'b0); send(CH_DOT, 1'b1);
		send_text("[]");
		send_text("[-]");
		send_text("[>>]");
		send_text("[-<+>]");
		send_text("[[->>+<<]]");

		random_program(130);
		send_idle = 72;
		recv_idle = 34;
		random_program(130);
		send_idle = 0;
		recv_idle = 0;
		random_program(120);

		case ($urandom_range(1))
			0: for (int i = open_depth; i >= 0; i--) send(CH_CLOSE, 1'b0);
			default: send(8'h80 | 8'($urandom_range(127)), 1'b0);
		endcase
		for (int i = 0; i < 40; i++) send(8'($urandom_range(255)), $urandom_range(1));
		@(negedge clk);
		in_ch.valid = 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.pending.size() != 0) sb.report("expected results left over");
		if (sb.mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

[bf_instruction_translator_unit.f]
rtl/bfit_pkg.sv
rtl/bfit_stream_if.sv
rtl/bfit_ram.sv
rtl/bf_instruction_translator_unit.sv
tb/sv/bf_instruction_translator_unit_tb.sv
